### rtl/core/ggap_pkg.sv
// Shared types, constants and helpers for the GGA position parser.
// Used by ggap_parser, ggap_coord_conv and nmea_gga_position_parser_core.
// No dependencies.
package ggap_pkg;

  localparam int FRAC_DIGITS_DEF = 5;
  localparam int E7_DIGITS       = 7;

  localparam logic [7:0] MAX_SENTENCE = 8'd150;
  localparam logic [7:0] START_COUNT  = 8'd6;   // "$GPGGA" already taken in
  localparam logic [4:0] FIELD_CHARS  = 5'd19;

  // received characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  localparam logic [63:0] HUNDRED     = 64'd100;
  localparam logic [63:0] MIN_PER_DEG = 64'd60;
  localparam logic [63:0] E7          = 64'd10000000;
  localparam logic [63:0] LAT_LIMIT   = 64'd900000000;
  localparam logic [63:0] LON_LIMIT   = 64'd1800000000;

  // register stages of the coordinate conversion
  localparam int CONV_STAGES = 10;

  // snapshot of a closed sentence, handed from parser to conversion
  typedef struct packed {
    logic [31:0] lat_digits;
    logic [2:0]  lat_scale;
    logic [31:0] lon_digits;
    logic [2:0]  lon_scale;
    logic        is_south;
    logic        is_west;
    logic [3:0]  quality;
    logic [6:0]  sats;
  } fix_rec_t;

  function automatic logic [63:0] pow10(input logic [2:0] k);
    logic [63:0] r;
    case (k)
      3'd0:    r = 64'd1;
      3'd1:    r = 64'd10;
      3'd2:    r = 64'd100;
      3'd3:    r = 64'd1000;
      3'd4:    r = 64'd10000;
      3'd5:    r = 64'd100000;
      3'd6:    r = 64'd1000000;
      default: r = 64'd10000000;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/ggap_parser.sv
// Byte-level GGA sentence parser: header match, field tracking, digit
// accumulation. Emits one fix_rec_t when a sentence with a position closes.
// Depends on ggap_pkg.
module ggap_parser #(
  parameter int FRAC_DIGITS = ggap_pkg::FRAC_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  output logic                emit,
  output ggap_pkg::fix_rec_t  rec
);

  localparam logic [2:0] FRAC_3 = 3'(FRAC_DIGITS);

  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_EW   = 4'd5;
  localparam logic [3:0] FLD_QUAL = 4'd6;
  localparam logic [3:0] FLD_SATS = 4'd7;
  localparam logic [3:0] FLD_END  = 4'd15;

  localparam logic [3:0] QUAL_CAP = 4'd9;
  localparam logic [6:0] SATS_CAP = 7'd99;

  typedef enum logic [2:0] {
    HDR_IDLE, HDR_DOLLAR, HDR_G, HDR_TALKER, HDR_G2, HDR_G3
  } hdr_t;

  hdr_t        hdr, hdr_next;
  logic        in_sentence, in_sentence_next;
  logic [3:0]  field_number, field_next;
  logic [7:0]  bytes_seen, bytes_next;
  logic [31:0] lat_digits, lat_next;
  logic [31:0] lon_digits, lon_next;
  logic [2:0]  lat_scale, lat_scale_next;
  logic [2:0]  lon_scale, lon_scale_next;
  logic [2:0]  fraction_count, fc_next;
  logic        point_seen, point_next;
  logic        number_ended, ended_next;
  logic [4:0]  kept_chars, kept_next;
  logic        lat_present, lat_present_next;
  logic        lon_present, lon_present_next;
  logic        is_south, south_next;
  logic        is_west, west_next;
  logic [3:0]  quality_value, quality_next;
  logic [6:0]  sat_value, sat_next;

  logic        finish;
  logic        is_digit;
  logic [3:0]  digit;
  logic [31:0] coord_sel, coord_new;
  logic [2:0]  coord_fc;
  logic        coord_point, coord_ended;
  logic [7:0]  qual_sum;
  logic [10:0] sat_sum;

  function automatic logic [31:0] push_digit(input logic [31:0] v, input logic [3:0] d);
    logic [35:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {32'd0, d};
    return (|t[35:32]) ? '1 : t[31:0];
  endfunction

  assign is_digit = (rx_byte >= ggap_pkg::CH_ZERO) && (rx_byte <= ggap_pkg::CH_NINE);
  assign digit    = 4'(rx_byte - ggap_pkg::CH_ZERO);
  assign qual_sum = {4'd0, quality_value} * 8'd10 + {4'd0, digit};
  assign sat_sum  = {4'd0, sat_value} * 11'd10 + {7'd0, digit};

  // one accumulator step, shared by latitude and longitude
  always_comb begin
    coord_sel   = (field_number == FLD_LAT) ? lat_digits : lon_digits;
    coord_new   = coord_sel;
    coord_fc    = fraction_count;
    coord_point = point_seen;
    coord_ended = number_ended;
    if (!number_ended) begin
      if (is_digit) begin
        if (!point_seen) begin
          coord_new = push_digit(coord_sel, digit);
        end else if (fraction_count < FRAC_3) begin
          coord_new = push_digit(coord_sel, digit);
          coord_fc  = fraction_count + 3'd1;
        end
      end else if (rx_byte == ggap_pkg::CH_POINT && !point_seen) begin
        coord_point = 1'b1;
      end else begin
        coord_ended = 1'b1;
      end
    end
  end

  always_comb begin
    hdr_next         = hdr;
    in_sentence_next = in_sentence;
    field_next       = field_number;
    bytes_next       = bytes_seen;
    lat_next         = lat_digits;
    lon_next         = lon_digits;
    lat_scale_next   = lat_scale;
    lon_scale_next   = lon_scale;
    fc_next          = fraction_count;
    point_next       = point_seen;
    ended_next       = number_ended;
    kept_next        = kept_chars;
    lat_present_next = lat_present;
    lon_present_next = lon_present;
    south_next       = is_south;
    west_next        = is_west;
    quality_next     = quality_value;
    sat_next         = sat_value;
    finish           = 1'b0;

    if (!in_sentence) begin
      if (rx_byte == ggap_pkg::CH_DOLLAR) begin
        hdr_next = HDR_DOLLAR;
      end else if (hdr == HDR_DOLLAR && rx_byte == ggap_pkg::CH_G) begin
        hdr_next = HDR_G;
      end else if (hdr == HDR_G &&
                   (rx_byte == ggap_pkg::CH_N || rx_byte == ggap_pkg::CH_P)) begin
        hdr_next = HDR_TALKER;
      end else if (hdr == HDR_TALKER && rx_byte == ggap_pkg::CH_G) begin
        hdr_next = HDR_G2;
      end else if (hdr == HDR_G2 && rx_byte == ggap_pkg::CH_G) begin
        hdr_next = HDR_G3;
      end else if (hdr == HDR_G3 && rx_byte == ggap_pkg::CH_A) begin
        hdr_next         = HDR_IDLE;
        in_sentence_next = 1'b1;
        field_next       = 4'd0;
        bytes_next       = ggap_pkg::START_COUNT;
        lat_next         = '0;
        lon_next         = '0;
        lat_scale_next   = '0;
        lon_scale_next   = '0;
        fc_next          = '0;
        point_next       = 1'b0;
        ended_next       = 1'b0;
        kept_next        = '0;
        lat_present_next = 1'b0;
        lon_present_next = 1'b0;
        south_next       = 1'b0;
        west_next        = 1'b0;
        quality_next     = '0;
        sat_next         = '0;
      end else begin
        hdr_next = HDR_IDLE;
      end
    end else if (rx_byte == ggap_pkg::CH_CR || rx_byte == ggap_pkg::CH_LF) begin
      finish = 1'b1;
    end else begin
      bytes_next = bytes_seen + 8'd1;
      if (rx_byte == ggap_pkg::CH_COMMA) begin
        // close the field; coordinates remember how far to scale up
        if (field_number == FLD_LAT) lat_scale_next = FRAC_3 - fraction_count;
        if (field_number == FLD_LON) lon_scale_next = FRAC_3 - fraction_count;
        fc_next    = '0;
        point_next = 1'b0;
        ended_next = 1'b0;
        kept_next  = '0;
        field_next = field_number + 4'd1;
        if (field_next == FLD_END) finish = 1'b1;
      end else if (rx_byte != ggap_pkg::CH_DOLLAR && kept_chars < ggap_pkg::FIELD_CHARS) begin
        kept_next = kept_chars + 5'd1;
        case (field_number)
          FLD_LAT: begin
            lat_present_next = 1'b1;
            lat_next         = coord_new;
            fc_next          = coord_fc;
            point_next       = coord_point;
            ended_next       = coord_ended;
          end
          FLD_NS: begin
            if (kept_chars == 5'd0) south_next = (rx_byte == ggap_pkg::CH_S);
          end
          FLD_LON: begin
            lon_present_next = 1'b1;
            lon_next         = coord_new;
            fc_next          = coord_fc;
            point_next       = coord_point;
            ended_next       = coord_ended;
          end
          FLD_EW: begin
            if (kept_chars == 5'd0) west_next = (rx_byte == ggap_pkg::CH_W);
          end
          FLD_QUAL: begin
            if (!number_ended) begin
              if (is_digit) quality_next = (qual_sum > 8'(QUAL_CAP)) ? QUAL_CAP : qual_sum[3:0];
              else ended_next = 1'b1;
            end
          end
          FLD_SATS: begin
            if (!number_ended) begin
              if (is_digit) sat_next = (sat_sum > 11'(SATS_CAP)) ? SATS_CAP : sat_sum[6:0];
              else ended_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (bytes_next >= ggap_pkg::MAX_SENTENCE) finish = 1'b1;
    end

    if (finish) begin
      in_sentence_next = 1'b0;
      hdr_next         = HDR_IDLE;
    end
  end

  assign emit = finish && lat_present_next && lon_present_next;

  // a coordinate field still open at close is scaled with its current count
  always_comb begin
    rec.lat_digits = lat_next;
    rec.lat_scale  = (field_next == FLD_LAT) ? FRAC_3 - fc_next : lat_scale_next;
    rec.lon_digits = lon_next;
    rec.lon_scale  = (field_next == FLD_LON) ? FRAC_3 - fc_next : lon_scale_next;
    rec.is_south   = south_next;
    rec.is_west    = west_next;
    rec.quality    = quality_next;
    rec.sats       = sat_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr            <= HDR_IDLE;
      in_sentence    <= 1'b0;
      field_number   <= '0;
      bytes_seen     <= '0;
      lat_digits     <= '0;
      lon_digits     <= '0;
      lat_scale      <= '0;
      lon_scale      <= '0;
      fraction_count <= '0;
      point_seen     <= 1'b0;
      number_ended   <= 1'b0;
      kept_chars     <= '0;
      lat_present    <= 1'b0;
      lon_present    <= 1'b0;
      is_south       <= 1'b0;
      is_west        <= 1'b0;
      quality_value  <= '0;
      sat_value      <= '0;
    end else if (fire) begin
      hdr            <= hdr_next;
      in_sentence    <= in_sentence_next;
      field_number   <= field_next;
      bytes_seen     <= bytes_next;
      lat_digits     <= lat_next;
      lon_digits     <= lon_next;
      lat_scale      <= lat_scale_next;
      lon_scale      <= lon_scale_next;
      fraction_count <= fc_next;
      point_seen     <= point_next;
      number_ended   <= ended_next;
      kept_chars     <= kept_next;
      lat_present    <= lat_present_next;
      lon_present    <= lon_present_next;
      is_south       <= south_next;
      is_west        <= west_next;
      quality_value  <= quality_next;
      sat_value      <= sat_next;
    end
  end

endmodule

### rtl/core/ggap_coord_conv.sv
// Pipelined DDMM.MMMMM fixed-point to degrees*1e7 conversion with clamp and
// hemisphere sign. Stage loads are driven by the top-level valid chain.
// Depends on ggap_pkg.
module ggap_coord_conv #(
  parameter int          FRAC_DIGITS = ggap_pkg::FRAC_DIGITS_DEF,
  parameter int          OUT_W       = 32,
  parameter logic [63:0] LIMIT       = ggap_pkg::LON_LIMIT
) (
  input  logic                               clk,
  input  logic [ggap_pkg::CONV_STAGES-1:0]   en,
  input  logic [31:0]                        digits,
  input  logic [2:0]                         scale,
  input  logic                               neg,
  output logic signed [OUT_W-1:0]            value
);

  localparam logic [63:0] SCALE   = ggap_pkg::pow10(3'(FRAC_DIGITS));
  localparam int          POW_W   = $clog2(SCALE + 64'd1);
  localparam logic [63:0] DEG_DIV = SCALE * ggap_pkg::HUNDRED;
  localparam logic [63:0] DEG_MAX = 64'hFFFF_FFFF / DEG_DIV;
  localparam int          DEG_W   = $clog2(DEG_MAX + 64'd1);
  localparam logic [63:0] RECIP   = 64'h1_0000_0000 / DEG_DIV;
  localparam int          MIN_W   = $clog2(DEG_DIV);
  localparam logic [63:0] MIN_MUL = ggap_pkg::pow10(3'(ggap_pkg::E7_DIGITS - FRAC_DIGITS));
  localparam int          T_W     = $clog2(DEG_DIV * MIN_MUL);
  localparam logic [63:0] RECIP60 = (64'd1 << T_W) / ggap_pkg::MIN_PER_DEG;
  localparam int          Q_W     = $clog2(RECIP60 + 64'd1);
  localparam int          DE_W    = DEG_W + $clog2(ggap_pkg::E7 + 64'd1);
  localparam int          SUM_W   = DE_W + 1;
  localparam int          NS      = ggap_pkg::CONV_STAGES;

  logic [NS-1:0]      n;
  logic [31:0]        d1;
  logic [2:0]         k1;
  logic [31:0]        sc2, sc3;
  logic [DEG_W-1:0]   q3, q4, deg5;
  logic [31:0]        rem4;
  logic [MIN_W-1:0]   mins5;
  logic [T_W-1:0]     t6, t7;
  logic [DE_W-1:0]    de6, de7, de8;
  logic [Q_W-1:0]     q7, frac8;
  logic [SUM_W-1:0]   sum9;

  logic [31+POW_W:0]  prod2;
  logic [63:0]        p3, qd4, p7, q60;
  logic [T_W-1:0]     r8;
  logic [OUT_W-1:0]   mag;

  assign prod2 = {{POW_W{1'b0}}, d1} * (32+POW_W)'(ggap_pkg::pow10(k1));
  assign p3    = {32'd0, sc2} * RECIP;
  assign qd4   = 64'(q3) * DEG_DIV;
  assign p7    = 64'(t6) * RECIP60;
  assign q60   = 64'(q7) * ggap_pkg::MIN_PER_DEG;
  assign r8    = t7 - q60[T_W-1:0];
  assign mag   = (64'(sum9) > LIMIT) ? LIMIT[OUT_W-1:0] : OUT_W'(sum9);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1   <= digits;
      k1   <= scale;
      n[0] <= neg;
    end
    // missing fraction digits: scale up, saturating
    if (en[1]) begin
      sc2  <= (|prod2[31+POW_W:32]) ? '1 : prod2[31:0];
      n[1] <= n[0];
    end
    // degrees estimate, may be one low
    if (en[2]) begin
      q3   <= p3[32 +: DEG_W];
      sc3  <= sc2;
      n[2] <= n[1];
    end
    if (en[3]) begin
      rem4 <= sc3 - qd4[31:0];
      q4   <= q3;
      n[3] <= n[2];
    end
    if (en[4]) begin
      if (rem4 >= DEG_DIV[31:0]) begin
        deg5  <= q3_plus(q4);
        mins5 <= MIN_W'(rem4 - DEG_DIV[31:0]);
      end else begin
        deg5  <= q4;
        mins5 <= MIN_W'(rem4);
      end
      n[4] <= n[3];
    end
    if (en[5]) begin
      t6   <= T_W'(64'(mins5) * MIN_MUL);
      de6  <= DE_W'(64'(deg5) * ggap_pkg::E7);
      n[5] <= n[4];
    end
    // minutes / 60 estimate, may be one low
    if (en[6]) begin
      q7   <= p7[T_W +: Q_W];
      t7   <= t6;
      de7  <= de6;
      n[6] <= n[5];
    end
    if (en[7]) begin
      frac8 <= (r8 >= T_W'(ggap_pkg::MIN_PER_DEG)) ? q7 + Q_W'(1) : q7;
      de8   <= de7;
      n[7]  <= n[6];
    end
    if (en[8]) begin
      sum9 <= SUM_W'(de8) + SUM_W'(frac8);
      n[8] <= n[7];
    end
    if (en[9]) begin
      value <= n[8] ? -mag : mag;
      n[9]  <= n[8];
    end
  end

  function automatic logic [DEG_W-1:0] q3_plus(input logic [DEG_W-1:0] q);
    return q + DEG_W'(1);
  endfunction

endmodule

### rtl/core/nmea_gga_position_parser_core.sv
// NMEA GGA position parser core: input register, byte parser and the
// pipelined latitude/longitude conversion. Depends on ggap_pkg, ggap_parser
// and ggap_coord_conv.
//
// Usage: rx_byte is offered with in_valid; a beat is taken on a clock edge
// with in_valid high and in_stall low. One byte can be taken every cycle while in_stall is low.
// A result beat (lat_e7, lon_e7, fix_quality, fix_class, satellites) is
// offered with out_valid and taken when out_stall is low; at most one result
// comes per GGA sentence, when the sentence closes with a position present.
// The result passes through the 10-stage conversion pipeline once the beat
// of the closing byte is taken (two reciprocal multiplies with their
// corrections, scale-up, sum and clamp).
// Throughput: one byte per cycle. While out_stall holds a result, bytes
// keep flowing and earlier results move up into free stages; in_stall rises
// only when a byte closes a sentence and the conversion pipeline is full.
// Reset (rst, synchronous) empties the pipeline and returns the parser to
// header search.
module nmea_gga_position_parser_core #(
  parameter int FRAC_DIGITS = ggap_pkg::FRAC_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [30:0] lat_e7,
  output logic signed [31:0] lon_e7,
  output logic [3:0]         fix_quality,
  output logic [2:0]         fix_class,
  output logic [6:0]         satellites
);

  localparam int NS = ggap_pkg::CONV_STAGES;

  localparam logic [2:0] CLS_NONE     = 3'd0;
  localparam logic [2:0] CLS_GPS      = 3'd1;
  localparam logic [2:0] CLS_DGPS     = 3'd2;
  localparam logic [2:0] CLS_RTK_FIX  = 3'd3;
  localparam logic [2:0] CLS_RTK_FLT  = 3'd4;

  localparam logic [3:0] QUAL_GPS     = 4'd1;
  localparam logic [3:0] QUAL_DGPS    = 4'd2;
  localparam logic [3:0] QUAL_RTK_FIX = 4'd4;
  localparam logic [3:0] QUAL_RTK_FLT = 4'd5;

  typedef struct packed {
    logic [3:0] quality;
    logic [2:0] cls;
    logic [6:0] sats;
  } side_t;

  logic               byte_valid;
  logic [7:0]         byte_q;
  logic               fire;
  logic               emit;
  ggap_pkg::fix_rec_t rec;
  logic [2:0]         rec_cls;
  logic [NS-1:0]      stage_valid;
  logic [NS:0]        stage_ready;
  logic [NS-1:0]      stage_en;
  side_t              side_q [NS];

  ggap_parser #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (byte_q),
    .emit    (emit),
    .rec     (rec)
  );

  ggap_coord_conv #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .OUT_W       (31),
    .LIMIT       (ggap_pkg::LAT_LIMIT)
  ) u_lat_conv (
    .clk    (clk),
    .en     (stage_en),
    .digits (rec.lat_digits),
    .scale  (rec.lat_scale),
    .neg    (rec.is_south),
    .value  (lat_e7)
  );

  ggap_coord_conv #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .OUT_W       (32),
    .LIMIT       (ggap_pkg::LON_LIMIT)
  ) u_lon_conv (
    .clk    (clk),
    .en     (stage_en),
    .digits (rec.lon_digits),
    .scale  (rec.lon_scale),
    .neg    (rec.is_west),
    .value  (lon_e7)
  );

  // a stage can load when empty or when the stage after it moves
  always_comb begin
    stage_ready[NS] = !out_stall;
    for (int i = NS - 1; i >= 0; i--) begin
      stage_ready[i] = !stage_valid[i] || stage_ready[i+1];
    end
  end

  assign fire     = byte_valid && (!emit || stage_ready[0]);
  assign in_stall = byte_valid && !fire;

  always_comb begin
    stage_en[0] = fire && emit;
    for (int i = 1; i < NS; i++) begin
      stage_en[i] = stage_ready[i] && stage_valid[i-1];
    end
  end

  always_comb begin
    case (rec.quality)
      QUAL_GPS:     rec_cls = CLS_GPS;
      QUAL_DGPS:    rec_cls = CLS_DGPS;
      QUAL_RTK_FIX: rec_cls = CLS_RTK_FIX;
      QUAL_RTK_FLT: rec_cls = CLS_RTK_FLT;
      default:      rec_cls = CLS_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid  <= 1'b0;
      stage_valid <= '0;
    end else begin
      if (!in_stall) byte_valid <= in_valid;
      if (stage_ready[0]) stage_valid[0] <= fire && emit;
      for (int i = 1; i < NS; i++) begin
        if (stage_ready[i]) stage_valid[i] <= stage_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) byte_q <= rx_byte;
    if (stage_en[0]) begin
      side_q[0].quality <= rec.quality;
      side_q[0].cls     <= rec_cls;
      side_q[0].sats    <= rec.sats;
    end
    for (int i = 1; i < NS; i++) begin
      if (stage_en[i]) side_q[i] <= side_q[i-1];
    end
  end

  assign out_valid   = stage_valid[NS-1];
  assign fix_quality = side_q[NS-1].quality;
  assign fix_class   = side_q[NS-1].cls;
  assign satellites  = side_q[NS-1].sats;

endmodule

### verif/tb_nmea_gga_position_parser_core.sv
// Testbench for nmea_gga_position_parser_core: byte driver, result monitor
// and a GGA sentence predictor whose fixes are checked field by field.
// Depends on ggap_pkg and the core RTL.
module tb_nmea_gga_position_parser_core;
  import ggap_pkg::*;

  localparam int FRAC         = FRAC_DIGITS_DEF;
  localparam int FIELD_END    = 15;
  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 25;

  // field positions within a GGA sentence
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_EW   = 4'd5;
  localparam logic [3:0] FLD_QUAL = 4'd6;
  localparam logic [3:0] FLD_SATS = 4'd7;

  // fix classes
  localparam logic [2:0] CLS_NONE      = 3'd0;
  localparam logic [2:0] CLS_GPS       = 3'd1;
  localparam logic [2:0] CLS_DGPS      = 3'd2;
  localparam logic [2:0] CLS_RTK_FIXED = 3'd3;
  localparam logic [2:0] CLS_RTK_FLOAT = 3'd4;

  typedef struct packed {
    logic [30:0] lat;
    logic [31:0] lon;
    logic [3:0]  quality;
    logic [2:0]  cls;
    logic [6:0]  sats;
  } gga_fix_t;

  typedef struct {
    logic [7:0] b;
    int         gap;
    bit         drain;
    bit         hold;
  } rx_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [30:0] lat_e7;
  logic signed [31:0] lon_e7;
  logic [3:0] fix_quality;
  logic [2:0] fix_class;
  logic [6:0] satellites;

  nmea_gga_position_parser_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .lat_e7      (lat_e7),
    .lon_e7      (lon_e7),
    .fix_quality (fix_quality),
    .fix_class   (fix_class),
    .satellites  (satellites)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- predictor state ----------------
  logic        gga_open;
  logic [2:0]  hdr_stage;
  logic [3:0]  field_idx;
  logic [7:0]  byte_cnt;
  logic [31:0] lat_acc, lon_acc;
  logic [2:0]  frac_cnt;
  logic        dot_seen, lat_seen, lon_seen, south, west;
  logic [3:0]  qual;
  logic [6:0]  sats;
  logic [4:0]  kept;
  logic        num_done;

  gga_fix_t fix_q[$];

  function automatic void gga_clear();
    gga_open = 1'b0; hdr_stage = '0; field_idx = '0; byte_cnt = '0;
    lat_acc = '0; lon_acc = '0; frac_cnt = '0; dot_seen = 1'b0;
    lat_seen = 1'b0; lon_seen = 1'b0; south = 1'b0; west = 1'b0;
    qual = '0; sats = '0; kept = '0; num_done = 1'b0;
  endfunction

  // decimal shift-in that sticks at all ones
  function automatic logic [31:0] acc_push(input logic [31:0] v, input logic [3:0] d);
    logic [63:0] t;
    t = {32'b0, v} * 64'd10 + {60'b0, d};
    return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  function automatic logic [31:0] coord_take(input logic [31:0] acc, input logic [7:0] c);
    logic [31:0] r;
    r = acc;
    if (!num_done) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!dot_seen) begin
          r = acc_push(acc, 4'(c - CH_ZERO));
        end else if (frac_cnt < FRAC) begin
          r = acc_push(acc, 4'(c - CH_ZERO));
          frac_cnt = frac_cnt + 3'd1;
        end
      end else if (c == CH_POINT && !dot_seen) begin
        dot_seen = 1'b1;
      end else begin
        num_done = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] count_take(input logic [6:0] v, input logic [7:0] c,
                                            input int cap);
    int t;
    if (num_done) return v;
    if (c < CH_ZERO || c > CH_NINE) begin
      num_done = 1'b1;
      return v;
    end
    t = int'(v) * 10 + int'(c - CH_ZERO);
    return (t > cap) ? 7'(cap) : 7'(t);
  endfunction

  // pad missing fraction digits with zeros
  function automatic logic [31:0] scale_frac(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    for (int i = int'(frac_cnt); i < FRAC; i++) r = acc_push(r, 4'd0);
    return r;
  endfunction

  function automatic void field_close();
    if (field_idx == FLD_LAT) lat_acc = scale_frac(lat_acc);
    else if (field_idx == FLD_LON) lon_acc = scale_frac(lon_acc);
    frac_cnt = '0;
    dot_seen = 1'b0;
    kept = '0;
    num_done = 1'b0;
  endfunction

  function automatic logic [63:0] deg_e7(input logic [31:0] v, input logic [63:0] lim);
    logic [63:0] s, deg, mins, r;
    s = 64'd1;
    for (int i = 0; i < FRAC; i++) s = s * 64'd10;
    deg  = {32'b0, v} / (HUNDRED * s);
    mins = {32'b0, v} - deg * HUNDRED * s;
    r    = deg * E7 + (mins * E7) / (MIN_PER_DEG * s);
    return (r > lim) ? lim : r;
  endfunction

  function automatic int sentence_close();
    gga_fix_t f;
    logic [63:0] la, lo;
    int n;
    n = 0;
    field_close();
    if (lat_seen && lon_seen) begin
      la = deg_e7(lat_acc, LAT_LIMIT);
      lo = deg_e7(lon_acc, LON_LIMIT);
      f.lat = south ? -la[30:0] : la[30:0];
      f.lon = west ? -lo[31:0] : lo[31:0];
      f.quality = qual;
      case (qual)
        4'd1:    f.cls = CLS_GPS;
        4'd2:    f.cls = CLS_DGPS;
        4'd4:    f.cls = CLS_RTK_FIXED;
        4'd5:    f.cls = CLS_RTK_FLOAT;
        default: f.cls = CLS_NONE;
      endcase
      f.sats = sats;
      fix_q.push_back(f);
      n = 1;
    end
    gga_open = 1'b0;
    hdr_stage = '0;
    return n;
  endfunction

  // one received byte; returns how many fixes it produced
  function automatic int gga_step(input logic [7:0] c);
    logic [2:0] p;
    if (!gga_open) begin
      p = hdr_stage;
      if (c == CH_DOLLAR) p = 3'd1;
      else if (p == 3'd1 && c == CH_G) p = 3'd2;
      else if (p == 3'd2 && (c == CH_N || c == CH_P)) p = 3'd3;
      else if ((p == 3'd3 || p == 3'd4) && c == CH_G) p = p + 3'd1;
      else if (p == 3'd5 && c == CH_A) begin
        gga_clear();
        gga_open = 1'b1;
        byte_cnt = START_COUNT;
        return 0;
      end else p = 3'd0;
      hdr_stage = p;
      return 0;
    end
    if (c == CH_CR || c == CH_LF) return sentence_close();
    byte_cnt = byte_cnt + 8'd1;
    if (c == CH_COMMA) begin
      field_close();
      field_idx = field_idx + 4'd1;
      if (field_idx >= FIELD_END) return sentence_close();
    end else if (c != CH_DOLLAR && kept < FIELD_CHARS) begin
      kept = kept + 5'd1;
      case (field_idx)
        FLD_LAT: begin
          lat_seen = 1'b1;
          lat_acc = coord_take(lat_acc, c);
        end
        FLD_NS:   if (kept == 5'd1) south = (c == CH_S);
        FLD_LON: begin
          lon_seen = 1'b1;
          lon_acc = coord_take(lon_acc, c);
        end
        FLD_EW:   if (kept == 5'd1) west = (c == CH_W);
        FLD_QUAL: qual = 4'(count_take({3'b0, qual}, c, 9));
        FLD_SATS: sats = count_take(sats, c, 99);
        default: ;
      endcase
    end
    if (byte_cnt >= MAX_SENTENCE) return sentence_close();
    return 0;
  endfunction

  // ---------------- stimulus ----------------
  rx_beat_t rx_pending[$];
  bit tight;
  bit next_drain, next_hold;
  int total_beats;

  task automatic put_byte(input logic [7:0] b);
    rx_beat_t e;
    e.b = b;
    e.gap = tight ? 0 : $urandom_range(0, 5);
    e.drain = next_drain;
    e.hold = next_hold;
    next_drain = 1'b0;
    next_hold = 1'b0;
    rx_pending.push_back(e);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_line(input string s);
    put_text(s);
    put_byte(CH_CR);
  endtask

  task automatic put_digits(input int n);
    for (int i = 0; i < n; i++) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic put_number(input int v, input int width);
    int d;
    d = 1;
    for (int i = 1; i < width; i++) d = d * 10;
    for (int i = 0; i < width; i++) begin
      put_byte(8'(int'(CH_ZERO) + (v / d) % 10));
      d = d / 10;
    end
  endtask

  task automatic put_coord(input int deg_max, input int deg_width);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return;                       // empty field
    if (r == 1) begin
      put_digits($urandom_range(1, 14));        // odd length, may saturate
    end else begin
      put_number($urandom_range(0, deg_max), deg_width);
      put_number($urandom_range(0, 59), 2);
    end
    if (r != 2) begin
      put_byte(CH_POINT);
      put_digits($urandom_range(0, 8));
    end
    if (r == 3) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic put_hemi(input string pos, input string neg);
    case ($urandom_range(0, 6))
      0: ;
      1, 2: put_text(pos);
      3, 4: put_text(neg);
      5: put_byte(8'($urandom_range(0, 255)));
      default: begin
        put_text(neg);
        put_text(pos);
      end
    endcase
  endtask

  task automatic put_random_sentence();
    int kind, n;
    tight = ($urandom_range(0, 4) == 0);
    kind = $urandom_range(0, 19);
    if (kind == 0) put_text("$GLGGA");
    else if (kind == 1) put_text("$GPGSA");
    else if (kind == 2) put_text("$GPG");
    else put_text($urandom_range(0, 1) ? "$GPGGA" : "$GNGGA");
    put_byte(CH_COMMA);
    put_digits($urandom_range(0, 6));
    put_byte(CH_COMMA);
    put_coord(($urandom_range(0, 9) == 0) ? 99 : 90, 2);
    put_byte(CH_COMMA);
    put_hemi("N", "S");
    put_byte(CH_COMMA);
    put_coord(($urandom_range(0, 9) == 0) ? 999 : 180, 3);
    put_byte(CH_COMMA);
    put_hemi("E", "W");
    put_byte(CH_COMMA);
    case ($urandom_range(0, 7))
      0:       ;
      1:       put_digits(2);
      2:       put_byte(8'($urandom_range(0, 255)));
      default: put_digits(1);
    endcase
    put_byte(CH_COMMA);
    if ($urandom_range(0, 7) == 0) put_byte(8'($urandom_range(0, 255)));
    put_digits($urandom_range(0, 3));
    n = ($urandom_range(0, 11) == 0) ? 12 : $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      put_byte(CH_COMMA);
      put_digits($urandom_range(0, 4));
    end
    // occasionally run past the sentence length limit
    if ($urandom_range(0, 11) == 0)
      for (int i = 0; i < 150; i++) put_byte(8'($urandom_range(8'h41, 8'h5A)));
    case ($urandom_range(0, 9))
      0: ;
      1: put_byte(CH_LF);
      2: put_byte(CH_CR);
      3: begin
        put_text("*4F");
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      default: begin
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------- counters and pressure ----------------
  int cycle_cnt = 0;
  int sent_cnt = 0;
  int want_cnt = 0;
  int got_cnt = 0;
  int err_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  wire hold_off = (hold_left != 0);
  wire calm = (cycle_cnt[11:10] == 2'b11);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // long receiver hold-off, kicked by a marked beat
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_go) hold_left <= HOLD_CYCLES;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("mismatch %s: got 0x%0h expected 0x%0h (fix %0d)", what, got, want, got_cnt);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin : drive
    int n;
    logic hg;
    hg = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        n = gga_step(rx_byte);
        want_cnt <= want_cnt + n;
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (rx_pending.size() != 0 &&
                     !(rx_pending[0].drain && got_cnt < want_cnt)) begin
          rx_byte <= rx_pending[0].b;
          in_valid <= 1'b1;
          gap_left <= rx_pending[0].gap;
          hg = rx_pending[0].hold;
          void'(rx_pending.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
    hold_go <= hg;
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin : watch
    gga_fix_t w;
    int nc;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      nc = stall_left;
      if (out_valid && !out_stall) begin
        got_cnt <= got_cnt + 1;
        if (fix_q.size() == 0) begin
          report_mismatch("unexpected fix beat", {32'b0, lon_e7}, 64'd0);
        end else begin
          w = fix_q.pop_front();
          check_field("lat_e7", {33'b0, lat_e7}, {33'b0, w.lat});
          check_field("lon_e7", {32'b0, lon_e7}, {32'b0, w.lon});
          check_field("fix_quality", {60'b0, fix_quality}, {60'b0, w.quality});
          check_field("fix_class", {61'b0, fix_class}, {61'b0, w.cls});
          check_field("satellites", {57'b0, satellites}, {57'b0, w.sats});
        end
        nc = calm ? 0 : $urandom_range(0, 5);
      end else if (nc != 0) begin
        nc = nc - 1;
      end
      stall_left <= nc;
      out_stall <= hold_off || (nc != 0);
    end
  end

  // ---------------- sequence ----------------
  initial begin : run
    int guard;
    gga_clear();
    tight = 1'b0;
    next_drain = 1'b0;
    next_hold = 1'b0;

    // directed: typical, extremes, every quality class
    put_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_text("$GNGGA,0,8959.99999,S,17959.99999,W,2,12,,");
    put_byte(CH_LF);
    put_line("$GPGGA,,9000.00000,N,18000.00000,E,4,99");
    put_line("$GPGGA,,0000.00000,S,00000.00000,W,0,00");
    // surplus and missing fraction digits
    put_line("$GPGGA,,1234.5678912,N,12345.123456789,E,5,7,");
    put_line("$GPGGA,,12,n,1.,e,3,150");
    // saturating accumulator, clamped degrees, saturating counts
    put_line("$GPGGA,,99999999999999,S,9999999999,W,37,123");
    // fields longer than the kept-character window
    put_line("$GPGGA,,0000000000000000001234.5,N,000000000000000000001,E,1,1");
    // signs, blanks and letters end a number
    put_line("$GPGGA,,45-12.5,SX,+120.5,WEST,x3, 5");
    put_text("$GPGGA,,12$34.5.6,s,1.2.3,w,6,9a");
    put_byte(CH_LF);
    // empty position gives nothing
    put_line("$GPGGA,,,N,123,E,1,05");
    put_line("$GPGGA,,4000,N,,E,1,05");
    put_line("$GPGGA");
    // header restarts and mismatches
    put_line("$GLGGA,,1,N,1,E,1,1");
    put_line("$G$GPGGA,,2,N,2,E,2,2");
    put_line("$GPGG$GNGGA,,3,N,3,E,4,3");
    put_line("$GPGGX,,1,N,1,E");
    put_line("GPGGA,,1,N,1,E");
    // fifteenth field closes the sentence
    put_line("$GPGGA,,1,N,1,E,1,1,,,,,,,,,5555,6666");
    // sentence length limit
    put_text("$GPGGA,,1,N,1,E,1,2,");
    for (int i = 0; i < 140; i++) put_byte(8'h78);
    put_byte(CH_CR);
    // all-ones, zero and high-bit bytes inside fields
    put_text("$GPGGA,,1");
    put_byte(8'hFF);
    put_text("5,N,2,E,");
    put_byte(8'h00);
    put_text(",1");
    put_byte(8'h80);
    put_byte(CH_CR);

    // burst of short sentences under a long receiver hold-off: fills the
    // conversion pipeline so the input side stalls
    tight = 1'b1;
    next_drain = 1'b1;
    next_hold = 1'b1;
    for (int i = 0; i < 16; i++) begin
      put_text("$GPGGA,,");
      put_digits($urandom_range(1, 4));
      put_text(",S,");
      put_digits($urandom_range(1, 5));
      put_text(",W,1,7");
      put_byte(CH_CR);
    end
    next_drain = 1'b1;

    for (int i = 0; i < 60; i++) begin
      if (i == 30) next_drain = 1'b1;
      put_random_sentence();
    end
    total_beats = rx_pending.size();

    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (sent_cnt != total_beats) @(posedge clk);
    guard = 0;
    while (got_cnt < want_cnt && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fix_q.size() != 0) report_mismatch("missing fix beats", fix_q.size(), 64'd0);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/ggap_pkg.sv
rtl/core/ggap_parser.sv
rtl/core/ggap_coord_conv.sv
rtl/core/nmea_gga_position_parser_core.sv
verif/tb_nmea_gga_position_parser_core.sv
